// ===== rtl/core/cqr_pkg.sv =====
// ----------------------------------------------------------------------------
// cqr_pkg: shared types and constants of the circular queue with rotate
// Operation codes, result record and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package cqr_pkg;

  localparam int CNT_W       = 5;   // count and capacity fields
  localparam int WORD_W      = 32;  // data_in and data_out fields
  localparam int SHIFT_W     = 4;   // shift_distance field
  localparam int FUNC_W      = 2;
  localparam int IN_TDATA_W  = 40;  // 38 bits of fields, padded to bytes
  localparam int OUT_TDATA_W = 40;  // 38 bits of fields, padded to bytes

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PROMOTE = 2'd2,
    OP_DEMOTE  = 2'd3
  } cqr_func_t;

  // One finished result on its way to the output register.
  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] data;
    logic [CNT_W-1:0]  count;
  } cqr_result_t;

endpackage

// ===== rtl/core/cqr_out_reg.sv =====
// ----------------------------------------------------------------------------
// cqr_out_reg: result holding register of the circular queue
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module cqr_out_reg
  import cqr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  cqr_result_t            res,
  output logic                   free,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] ok, [32:1] data_out, [37:33] count, [39:38] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  cqr_result_t held;

  // A new result may enter when the register is empty or is emptied now.
  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_axis_tdata = {2'b00, held.count, held.data, held.ok};

endmodule

// ===== rtl/core/circular_queue_with_rotate.sv =====
// ----------------------------------------------------------------------------
// circular_queue_with_rotate: ring-buffer queue with push, pop and rotations
// A queue over a ring whose length is set by the capacity register. Besides
// push and pop it can move the tail entry toward the head (promote) or the
// head entry toward the tail (demote) by a given number of places.
// ----------------------------------------------------------------------------
//
//  channel   signals                          carries
//  --------  -------------------------------  ---------------------------------
//  input     s_axis_tvalid/tready/tdata       func, data_in, shift_distance
//  result    m_axis_tvalid/tready/tdata       ok, data_out, count
//  config    cfg_valid/cfg_ready/cfg_data     capacity (5 bits)
//
//  Push, pop and every failed operation go from the idle state to the finish
//  state, from which their result enters the output register. A successful
//  rotation by n places walks the ring and writes the moved entry last, paced
//  by the single read port and single write port of the ring memory: one
//  entry is read and one entry moved per cycle.
//  Reset is synchronous and leaves the queue empty with a capacity of 16; the
//  ring memory itself is not cleared. A capacity write also empties the queue.
//  A new item is taken while a result still waits in the output register; a
//  stalled output only holds the block in its final step.
// ----------------------------------------------------------------------------
module circular_queue_with_rotate
  import cqr_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [1:0] func, [33:2] data_in, [37:34] shift_distance, [39:38] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] ok, [32:1] data_out, [37:33] count, [39:38] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Index arithmetic width: wide enough for an index plus one and for count.
  localparam int CW = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  // Largest ring length the capacity register can select in this build.
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'((DEPTH < 31) ? DEPTH : 31);
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'((DEPTH < 16) ? DEPTH : 16);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_ROT     = 4'b0010,
    ST_ROTLAST = 4'b0100,
    ST_FINISH  = 4'b1000
  } state_t;

  // Capacity as it acts: zero reads as one, anything above the depth as the
  // depth.
  function automatic logic [CNT_W-1:0] eff_of(input logic [CNT_W-1:0] c);
    if (c == '0) begin
      return CNT_W'(1);
    end else if (c > CAP_MAX) begin
      return CAP_MAX;
    end else begin
      return c;
    end
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i,
                                               input logic [CNT_W-1:0] e);
    logic [CW-1:0] s;
    s = CW'(i) + CW'(1);
    return (s == CW'(e)) ? '0 : s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i,
                                               input logic [CNT_W-1:0] e);
    return (i == '0) ? IDX_W'(e - CNT_W'(1)) : i - IDX_W'(1);
  endfunction

  // Queue state.
  state_t                state;
  logic [CNT_W-1:0]      eff_cap;
  logic [IDX_W-1:0]      head;
  logic [IDX_W-1:0]      tail;
  logic [CNT_W-1:0]      count;

  // Rotation walk: rd_ptr is the entry read last, prev_ptr the one before it.
  logic [IDX_W-1:0]      rd_ptr;
  logic [IDX_W-1:0]      prev_ptr;
  logic [SHIFT_W-1:0]    remaining;
  logic                  first;
  logic                  fwd;        // 1 walks toward the tail (demote)
  logic [DATA_WIDTH-1:0] moved;

  // Result bookkeeping.
  logic                  res_ok;
  logic                  res_pop;

  // Ring memory: one write port, one registered read port.
  logic [DATA_WIDTH-1:0] ring [DEPTH];
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // Input decode.
  cqr_func_t             op;
  logic [WORD_W-1:0]     data_in;
  logic [SHIFT_W-1:0]    shift_distance;
  logic [63:0]           din_ext;
  logic [63:0]           dout_ext;
  logic                  in_go;
  logic                  cfg_go;
  logic                  op_ok;
  logic [IDX_W-1:0]      tail_inc;
  logic [IDX_W-1:0]      head_inc;
  logic [IDX_W-1:0]      walk_next;

  // Output side.
  logic                  out_free;
  logic                  out_load;
  cqr_result_t           result;

  assign op             = cqr_func_t'(s_axis_tdata[FUNC_W-1:0]);
  assign data_in        = s_axis_tdata[FUNC_W +: WORD_W];
  assign shift_distance = s_axis_tdata[FUNC_W+WORD_W +: SHIFT_W];
  assign din_ext        = 64'(data_in);

  // Configuration is taken only between items and wins over a new item.
  assign cfg_ready     = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;
  assign cfg_go        = cfg_valid && cfg_ready;
  assign in_go         = s_axis_tvalid && s_axis_tready;

  assign tail_inc  = idx_inc(tail, eff_cap);
  assign head_inc  = idx_inc(head, eff_cap);
  assign walk_next = fwd ? idx_inc(rd_ptr, eff_cap) : idx_dec(rd_ptr, eff_cap);

  // Whether the operation can be done with the present fill.
  always_comb begin
    unique case (op)
      OP_PUSH:    op_ok = (count < eff_cap);
      OP_POP:     op_ok = (count != '0);
      OP_PROMOTE: op_ok = (count > CNT_W'(shift_distance));
      OP_DEMOTE:  op_ok = (count > CNT_W'(shift_distance));
      default:    op_ok = 1'b0;
    endcase
  end

  // Memory port steering. The rotation writes the word in the read register
  // into the entry walked before it while reading the next one; the walked
  // entries are distinct, so the read and the write never meet on one entry.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tail_inc;
    mem_wdata = din_ext[DATA_WIDTH-1:0];
    mem_re    = 1'b0;
    mem_raddr = walk_next;
    unique case (state)
      ST_IDLE: begin
        if (in_go && op_ok) begin
          unique case (op)
            OP_PUSH: begin
              mem_we = 1'b1;
            end
            OP_POP: begin
              mem_re    = 1'b1;
              mem_raddr = head;
            end
            OP_PROMOTE: begin
              mem_re    = 1'b1;
              mem_raddr = tail;
            end
            OP_DEMOTE: begin
              mem_re    = 1'b1;
              mem_raddr = head;
            end
            default: begin
              mem_re = 1'b0;
            end
          endcase
        end
      end
      ST_ROT: begin
        mem_we    = !first;
        mem_waddr = prev_ptr;
        mem_wdata = mem_rdata;
        mem_re    = (remaining != '0);
      end
      ST_ROTLAST: begin
        mem_we    = 1'b1;
        mem_waddr = rd_ptr;
        mem_wdata = moved;
      end
      ST_FINISH: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= ring[mem_raddr];
    end
  end

  // Control and pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      eff_cap <= CAP_RESET;
      head    <= '0;
      tail    <= IDX_W'(CAP_RESET - CNT_W'(1));
      count   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cfg_go) begin
            eff_cap <= eff_of(cfg_data);
            head    <= '0;
            tail    <= IDX_W'(eff_of(cfg_data) - CNT_W'(1));
            count   <= '0;
          end else if (in_go) begin
            state <= ST_FINISH;
            if (op_ok) begin
              unique case (op)
                OP_PUSH: begin
                  tail  <= tail_inc;
                  count <= count + CNT_W'(1);
                end
                OP_POP: begin
                  head  <= head_inc;
                  count <= count - CNT_W'(1);
                end
                OP_PROMOTE: state <= ST_ROT;
                OP_DEMOTE:  state <= ST_ROT;
                default:    state <= ST_FINISH;
              endcase
            end
          end
        end
        ST_ROT: begin
          if (remaining == '0) begin
            state <= ST_ROTLAST;
          end
        end
        ST_ROTLAST: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Rotation walk and result bookkeeping.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_go) begin
      res_ok    <= op_ok;
      res_pop   <= (op == OP_POP) && op_ok;
      fwd       <= (op == OP_DEMOTE);
      rd_ptr    <= (op == OP_DEMOTE) ? head : tail;
      remaining <= shift_distance;
      first     <= 1'b1;
    end else if (state == ST_ROT) begin
      first <= 1'b0;
      if (first) begin
        moved <= mem_rdata;
      end
      if (remaining != '0) begin
        prev_ptr  <= rd_ptr;
        rd_ptr    <= walk_next;
        remaining <= remaining - SHIFT_W'(1);
      end
    end
  end

  // The popped word stays in the read register until the result is loaded.
  assign dout_ext     = 64'(mem_rdata);
  assign result.ok    = res_ok;
  assign result.data  = res_pop ? dout_ext[WORD_W-1:0] : '0;
  assign result.count = count;
  assign out_load     = (state == ST_FINISH) && out_free;

  cqr_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (out_load),
    .res           (result),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= eff_cap)
    else $error("entry count exceeds ring length");

  a_pointers_in_ring: assert property (@(posedge clk) disable iff (rst)
    (CW'(head) < CW'(eff_cap)) && (CW'(tail) < CW'(eff_cap)))
    else $error("head or tail outside the ring");

  a_failed_op_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (in_go && !op_ok) |=> (count == $past(count)) && (head == $past(head))
                          && (tail == $past(tail)))
    else $error("failed operation changed the queue");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == ST_IDLE) |-> (in_go && op == OP_PUSH && op_ok))
    else $error("ring written without an accepted push");
`endif

endmodule

// ===== bench/tb_circular_queue_with_rotate.sv =====
// ----------------------------------------------------------------------------
// tb_circular_queue_with_rotate: self-checking bench of the rotating ring queue
// Sends push, pop, promote and demote items at a range of capacity settings,
// predicts every result with a behavioral copy of the queue and compares each
// returned item field by field, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
module tb_circular_queue_with_rotate;
  import cqr_pkg::*;

  localparam int RING_DEPTH    = 16;
  localparam int SETTLE_CYCLES = 24;    // longest rotation plus margin
  localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
  localparam int PHASE_ITEMS   = 160;
  localparam int NUM_PHASES    = 8;
  localparam int MAX_PRINTED   = 40;

  // Behavioral copy of the queue plus the results it still owes.
  class rotq_scoreboard;
    int unsigned       ring_len;
    logic [WORD_W-1:0] ring [RING_DEPTH];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       held;
    cqr_result_t       pending_results [$];
    int unsigned       errors;

    function new();
      errors = 0;
      set_capacity(5'd16);
    endfunction

    // A capacity write clamps the ring length and empties the queue.
    function void set_capacity(logic [CNT_W-1:0] value);
      if (value == '0) ring_len = 1;
      else if (32'(value) > RING_DEPTH) ring_len = RING_DEPTH;
      else ring_len = 32'(value);
      head = 0;
      tail = ring_len - 1;
      held = 0;
    endfunction

    function int unsigned step_fwd(int unsigned base, int unsigned off);
      return (base + off % ring_len) % ring_len;
    endfunction

    function int unsigned step_back(int unsigned base, int unsigned off);
      return (base + ring_len - off % ring_len) % ring_len;
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("[%0t] mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Applies one accepted item to the copy and queues the result it causes.
    function void note_item(cqr_func_t op, logic [WORD_W-1:0] word,
                            logic [SHIFT_W-1:0] shift);
      cqr_result_t       r;
      logic [WORD_W-1:0] moved;
      int unsigned       span;
      r.ok   = 1'b0;
      r.data = '0;
      span   = 32'(shift);
      case (op)
        OP_PUSH: begin
          if (held < ring_len) begin
            tail = step_fwd(tail, 1);
            ring[tail] = word;
            held++;
            r.ok = 1'b1;
          end
        end
        OP_POP: begin
          if (held > 0) begin
            r.data = ring[head];
            head = step_fwd(head, 1);
            held--;
            r.ok = 1'b1;
          end
        end
        OP_PROMOTE: begin
          // The tail entry jumps toward the head; the ones it passes slide back.
          if (held > span) begin
            moved = ring[tail];
            for (int i = 0; i < span; i++)
              ring[step_back(tail, i)] = ring[step_back(tail, i + 1)];
            ring[step_back(tail, span)] = moved;
            r.ok = 1'b1;
          end
        end
        default: begin
          // The head entry sinks toward the tail; the ones it passes move up.
          if (held > span) begin
            moved = ring[head];
            for (int i = 0; i < span; i++)
              ring[step_fwd(head, i)] = ring[step_fwd(head, i + 1)];
            ring[step_fwd(head, span)] = moved;
            r.ok = 1'b1;
          end
        end
      endcase
      r.count = CNT_W'(held);
      pending_results.push_back(r);
    endfunction

    task check_result(logic [OUT_TDATA_W-1:0] beat);
      cqr_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(beat), 64'(0));
      end else begin
        want = pending_results.pop_front();
        if (beat[0] !== want.ok) report_mismatch("ok", 64'(beat[0]), 64'(want.ok));
        if (beat[32:1] !== want.data)
          report_mismatch("data_out", 64'(beat[32:1]), 64'(want.data));
        if (beat[37:33] !== want.count)
          report_mismatch("count", 64'(beat[37:33]), 64'(want.count));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data = '0;

  rotq_scoreboard sb;
  bit             idle_enable = 1'b1;  // random idle bursts on both streams
  bit             filling = 1'b1;      // bias toward pushes until the ring is full
  int unsigned    sink_stall = 0;
  int unsigned    quiet_cycles = 0;

  always #2 clk = ~clk;

  circular_queue_with_rotate dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Result side: every accepted item is checked against the oldest prediction.
  // The ready line drops in random bursts while idling is on.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(1, 4) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: any handshake restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Presents one item, holds it until accepted and records it in the copy.
  // Called and left at a rising edge; valid stays high unless an idle burst
  // follows, so back-to-back items never see valid pulse low.
  task automatic send_item(cqr_func_t op, logic [WORD_W-1:0] word,
                           logic [SHIFT_W-1:0] shift);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, shift, word, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(op, word, shift);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Capacity is written only with the queue drained and the block at rest.
  task automatic write_capacity(logic [CNT_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_capacity(value);
    filling = 1'b1;
  endtask

  // Mostly well-formed traffic: the queue is filled and drained in turns, and
  // most rotations use a distance the current count allows, so that they do
  // real work. The rest are opposite operations and rotations of any length.
  task automatic send_random_item();
    cqr_func_t          op;
    logic [WORD_W-1:0]  word;
    logic [SHIFT_W-1:0] shift;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = filling ? OP_PUSH : OP_POP;
    else if (pick < 58) op = filling ? OP_POP : OP_PUSH;
    else op = $urandom_range(0, 1) ? OP_PROMOTE : OP_DEMOTE;
    if (pick >= 90 || sb.held == 0) shift = SHIFT_W'($urandom_range(0, 15));
    else shift = SHIFT_W'($urandom_range(0, sb.held - 1));
    case ($urandom_range(0, 9))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    send_item(op, word, shift);
    if (sb.held >= sb.ring_len) filling = 1'b0;
    else if (sb.held == 0) filling = 1'b1;
  endtask

  initial begin
    logic [CNT_W-1:0] phase_caps [NUM_PHASES];
    sb = new();
    // Extremes first: the built depth, a single entry, zero (acts as one) and a
    // value above the depth (acts as the depth); then two entries, the depth and random settings.
    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'd16, 5'd16};
    phase_caps[5] = CNT_W'($urandom_range(3, 15));
    phase_caps[7] = CNT_W'($urandom_range(0, 31));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part on a ring of four entries: empty and full refusals, data
    // extremes, rotations by zero, by count minus one and by too many places.
    write_capacity(5'd4);
    send_item(OP_POP,     32'h0000_0000, 4'd0);
    send_item(OP_DEMOTE,  32'h0000_0000, 4'd0);
    send_item(OP_PUSH,    32'h0000_0000, 4'd15);
    send_item(OP_PUSH,    32'hFFFF_FFFF, 4'd0);
    send_item(OP_PUSH,    32'h1234_5678, 4'd0);
    send_item(OP_PUSH,    32'h8000_0001, 4'd0);
    send_item(OP_PUSH,    32'hDEAD_BEEF, 4'd0);
    send_item(OP_PROMOTE, 32'hFFFF_FFFF, 4'd3);
    send_item(OP_PROMOTE, 32'h0000_0000, 4'd4);
    send_item(OP_DEMOTE,  32'h0000_0000, 4'd3);
    send_item(OP_DEMOTE,  32'h0000_0000, 4'd0);
    send_item(OP_PROMOTE, 32'h0000_0000, 4'd0);
    send_item(OP_PROMOTE, 32'h0000_0000, 4'd1);
    send_item(OP_DEMOTE,  32'h0000_0000, 4'd2);
    send_item(OP_DEMOTE,  32'h0000_0000, 4'd15);
    repeat (4) send_item(OP_POP, 32'hFFFF_FFFF, 4'd15);
    send_item(OP_POP,     32'h0000_0000, 4'd0);
    send_item(OP_PROMOTE, 32'h0000_0000, 4'd15);

    // Random phases; the last one runs with both streams at full speed.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      idle_enable = (p != NUM_PHASES - 1);
      repeat (PHASE_ITEMS) send_random_item();
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== circular_queue_with_rotate.f =====
rtl/core/cqr_pkg.sv
rtl/core/cqr_out_reg.sv
rtl/core/circular_queue_with_rotate.sv
bench/tb_circular_queue_with_rotate.sv
